>>> src/bchd_pkg.sv
// shared types and constants for the button chord hold decoder
`default_nettype none

package bchd_pkg;

   localparam int TimeW      = 16;
   localparam int StepW      = 17;
   localparam int NumButtons = 4;
   localparam int CsrIndexW  = 3;
   localparam int MaxResults = 6;
   localparam int CountW     = 3;
   localparam int NumCand    = 7;
   localparam int QueueDepth = 2;

   localparam int BtnUp    = 0;
   localparam int BtnRight = 1;
   localparam int BtnDown  = 2;
   localparam int BtnLeft  = 3;

   localparam logic [CsrIndexW-1:0] CsrFocusSwitch = 3'd0;
   localparam logic [CsrIndexW-1:0] CsrFocusFast   = 3'd1;
   localparam logic [CsrIndexW-1:0] CsrFocusSlow   = 3'd2;
   localparam logic [CsrIndexW-1:0] CsrHomeHold    = 3'd3;
   localparam logic [CsrIndexW-1:0] CsrModeHold    = 3'd4;

   localparam logic [TimeW-1:0] FocusSwitchReset = 16'd1000;
   localparam logic [TimeW-1:0] FocusFastReset   = 16'd100;
   localparam logic [TimeW-1:0] FocusSlowReset   = 16'd10;
   localparam logic [TimeW-1:0] HomeHoldReset    = 16'd1000;
   localparam logic [TimeW-1:0] ModeHoldReset    = 16'd500;

   localparam logic OpSample  = 1'b0;
   localparam logic OpProcess = 1'b1;

   typedef enum logic [2:0] {
      CMD_NONE     = 3'd0,
      CMD_FOCUS    = 3'd1,
      CMD_SET_HOME = 3'd2,
      CMD_GO_HOME  = 3'd3,
      CMD_NORTH    = 3'd4,
      CMD_SOUTH    = 3'd5,
      CMD_WEST     = 3'd6,
      CMD_EAST     = 3'd7
   } command_type;

   typedef struct packed {
      command_type command;
      logic        mode;
   } entry_type;

   typedef struct packed {
      entry_type [MaxResults-1:0] entries;
      logic [CountW-1:0]          count;
      logic [StepW-1:0]           step;
   } job_type;

endpackage

`default_nettype wire

>>> src/bchd_front.sv
// front end: config registers, button latch, hold timers and command list decode
`default_nettype none

module bchd_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [bchd_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic [bchd_pkg::TimeW-1:0]     csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_op,
   input  wire logic [bchd_pkg::NumButtons-1:0] req_buttons,
   input  wire logic [bchd_pkg::TimeW-1:0]     req_elapsed_ms,
   input  wire logic                           queue_full,
   output logic                                push,
   output bchd_pkg::job_type                   push_job
);
   import bchd_pkg::*;

   logic [TimeW-1:0] focus_switch_ff, focus_fast_ff, focus_slow_ff, home_hold_ff, mode_hold_ff;
   logic [NumButtons-1:0] held_ff, held_in;
   logic [TimeW-1:0] hold_ff [NumButtons];
   logic [TimeW-1:0] hold_in [NumButtons];
   logic consumed_ff, scope_ff, scope_in;

   logic accept;
   logic up, right, down, left;
   logic focus_run, to_scope, mode_a, scope_run, to_focus, mode_b;
   logic [TimeW-1:0] size_up, size_down;
   logic [StepW-1:0] step;
   logic [NumCand-1:0] cand_v;
   entry_type cand_e [NumCand];
   logic [CountW-1:0] fill;
   logic [TimeW:0] hold_sum [NumButtons];

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && (req_op == OpProcess);

   // sample beat: latch and hold timers
   always_comb begin
      held_in = consumed_ff ? req_buttons : (req_buttons | held_ff);
      for (int i = 0; i < NumButtons; i++) begin
         hold_sum[i] = {1'b0, hold_ff[i]} + {1'b0, req_elapsed_ms};
         if (held_in[i] && held_ff[i]) begin
            hold_in[i] = hold_sum[i][TimeW] ? '1 : hold_sum[i][TimeW-1:0];
         end else begin
            hold_in[i] = '0;
         end
      end
   end

   // process beat: rules and mode machine
   always_comb begin
      up    = held_ff[BtnUp];
      right = held_ff[BtnRight];
      down  = held_ff[BtnDown];
      left  = held_ff[BtnLeft];

      size_up   = (hold_ff[BtnUp] > focus_switch_ff) ? focus_fast_ff : focus_slow_ff;
      size_down = (hold_ff[BtnDown] > focus_switch_ff) ? focus_fast_ff : focus_slow_ff;
      step = (up && !down) ? {1'b0, size_up} : (StepW'(0) - {1'b0, size_down});

      focus_run = !scope_ff;
      to_scope  = focus_run && up && right
                  && (hold_ff[BtnUp] > mode_hold_ff) && (hold_ff[BtnRight] > mode_hold_ff);
      mode_a    = scope_ff || to_scope;
      scope_run = mode_a && !consumed_ff;
      to_focus  = scope_run && down && left
                  && (hold_ff[BtnDown] > mode_hold_ff) && (hold_ff[BtnLeft] > mode_hold_ff);
      mode_b    = mode_a && !to_focus;
      scope_in  = mode_b;

      cand_v[0] = focus_run && (up != down);
      cand_v[1] = focus_run && up && down
                  && (hold_ff[BtnUp] > home_hold_ff) && (hold_ff[BtnDown] > home_hold_ff);
      cand_v[2] = focus_run && left && right
                  && (hold_ff[BtnLeft] > home_hold_ff) && (hold_ff[BtnRight] > home_hold_ff);
      cand_v[3] = scope_run && up;
      cand_v[4] = scope_run && down;
      cand_v[5] = scope_run && left;
      cand_v[6] = scope_run && right;

      cand_e[0] = '{command: CMD_FOCUS,    mode: 1'b0};
      cand_e[1] = '{command: CMD_SET_HOME, mode: 1'b0};
      cand_e[2] = '{command: CMD_GO_HOME,  mode: 1'b0};
      cand_e[3] = '{command: CMD_NORTH,    mode: mode_b};
      cand_e[4] = '{command: CMD_SOUTH,    mode: mode_b};
      cand_e[5] = '{command: CMD_WEST,     mode: mode_b};
      cand_e[6] = '{command: CMD_EAST,     mode: mode_b};

      push_job = '0;
      fill     = '0;
      for (int i = 0; i < NumCand; i++) begin
         if (cand_v[i] && (fill < CountW'(MaxResults))) begin
            push_job.entries[fill] = cand_e[i];
            fill = fill + 1'b1;
         end
      end
      if (fill == '0) begin
         push_job.entries[0] = '{command: CMD_NONE, mode: mode_b};
         fill = CountW'(1);
      end
      push_job.count = fill;
      push_job.step  = cand_v[0] || (focus_run && !up && down) ? step : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focus_switch_ff <= FocusSwitchReset;
         focus_fast_ff   <= FocusFastReset;
         focus_slow_ff   <= FocusSlowReset;
         home_hold_ff    <= HomeHoldReset;
         mode_hold_ff    <= ModeHoldReset;
         held_ff         <= '0;
         consumed_ff     <= 1'b0;
         scope_ff        <= 1'b0;
         for (int i = 0; i < NumButtons; i++) begin
            hold_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CsrFocusSwitch: focus_switch_ff <= csr_wdata;
               CsrFocusFast:   focus_fast_ff   <= csr_wdata;
               CsrFocusSlow:   focus_slow_ff   <= csr_wdata;
               CsrHomeHold:    home_hold_ff    <= csr_wdata;
               CsrModeHold:    mode_hold_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            if (req_op == OpSample) begin
               held_ff     <= held_in;
               consumed_ff <= 1'b0;
               for (int i = 0; i < NumButtons; i++) begin
                  hold_ff[i] <= hold_in[i];
               end
            end else begin
               consumed_ff <= 1'b1;
               scope_ff    <= scope_in;
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> src/bchd_queue.sv
// short command-list queue between front and back end
`default_nettype none

module bchd_queue #(
   parameter int Depth = bchd_pkg::QueueDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bchd_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output bchd_pkg::job_type      head_job
);
   import bchd_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> src/bchd_back.sv
// back end: walks one command list and drives the result register
`default_nettype none

module bchd_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         head_valid,
   input  wire bchd_pkg::job_type            head_job,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [2:0]                        rsp_command,
   output logic signed [bchd_pkg::StepW-1:0] rsp_focus_step,
   output logic                              rsp_mode,
   output logic                              rsp_last
);
   import bchd_pkg::*;

   logic busy_ff;
   job_type cur_ff;
   logic [CountW-1:0] idx_ff;
   logic rsp_valid_ff, rsp_mode_ff, rsp_last_ff;
   command_type rsp_command_ff;
   logic [StepW-1:0] rsp_step_ff;

   logic emit, is_last;
   entry_type sel;

   assign sel     = cur_ff.entries[idx_ff];
   assign is_last = (idx_ff == (cur_ff.count - 1'b1));
   assign emit    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign pop     = head_valid && (!busy_ff || (emit && is_last));

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_command    = rsp_command_ff;
   assign rsp_focus_step = rsp_step_ff;
   assign rsp_mode       = rsp_mode_ff;
   assign rsp_last       = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            busy_ff <= 1'b1;
         end else if (emit && is_last) begin
            busy_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_job;
         idx_ff <= '0;
      end else if (emit) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (emit) begin
         rsp_command_ff <= sel.command;
         rsp_mode_ff    <= sel.mode;
         rsp_last_ff    <= is_last;
         rsp_step_ff    <= (sel.command == CMD_FOCUS) ? cur_ff.step : '0;
      end
   end

endmodule

`default_nettype wire

>>> src/button_chord_hold_decoder.sv
// Four-button chord and hold decoder. A sample beat (op 0) latches the buttons and updates the
// per-button hold timers; a process beat (op 1) is decoded combinationally into a list
// of one to six commands, which is queued and then issued one result per cycle from the result
// register while rsp_ready is high, the final one flagged with last. Input beats are taken every
// cycle while the command queue (QueueDepth lists) has room. A process beat yields 1 to 6
// results, a sample beat none. The first result of a process beat passes through the queue, the
// back end list register and result register. Configuration writes take effect on the next beat.
`default_nettype none

module button_chord_hold_decoder #(
   parameter int QueueDepth = bchd_pkg::QueueDepth
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [bchd_pkg::CsrIndexW-1:0]  csr_index,
   input  wire logic [bchd_pkg::TimeW-1:0]      csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_op,
   input  wire logic [bchd_pkg::NumButtons-1:0] req_buttons,
   input  wire logic [bchd_pkg::TimeW-1:0]      req_elapsed_ms,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [2:0]                           rsp_command,
   output logic signed [bchd_pkg::StepW-1:0]    rsp_focus_step,
   output logic                                 rsp_mode,
   output logic                                 rsp_last
);
   import bchd_pkg::*;

   logic push, full, pop, head_valid;
   job_type push_job, head_job;

   bchd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_buttons    (req_buttons),
      .req_elapsed_ms (req_elapsed_ms),
      .queue_full     (full),
      .push           (push),
      .push_job       (push_job)
   );

   bchd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   bchd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_command    (rsp_command),
      .rsp_focus_step (rsp_focus_step),
      .rsp_mode       (rsp_mode),
      .rsp_last       (rsp_last)
   );

   // a none command always stands alone
   a_none_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == CMD_NONE) |-> rsp_last)
      else $error("none command not flagged last");

   // focus and home commands come from focus mode only
   a_focus_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_command == CMD_FOCUS) || (rsp_command == CMD_SET_HOME)
                    || (rsp_command == CMD_GO_HOME)) |-> !rsp_mode)
      else $error("focus-mode command issued in scope mode");

   // step is carried by focus commands alone
   a_step_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command != CMD_FOCUS) |-> (rsp_focus_step == '0))
      else $error("nonzero step on non-focus command");

   // a list is only taken by the back end when the queue holds one
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

endmodule

`default_nettype wire
